// File: rtl/msrs_pkg.sv
package msrs_pkg;

	// item kinds
	localparam logic [1:0] KIND_LOAD_LINK  = 2'd0;
	localparam logic [1:0] KIND_LOAD_MERGE = 2'd1;
	localparam logic [1:0] KIND_REQUEST    = 2'd2;

	// result status codes
	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_INVALID   = 2'd1;
	localparam logic [1:0] STATUS_NO_ROUTE  = 2'd2;
	localparam logic [1:0] STATUS_AMBIGUOUS = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_LINK_USED   = 2'd0;
	localparam logic [1:0] CFG_MERGE_USED  = 2'd1;
	localparam logic [1:0] CFG_RELOC_KIND  = 2'd2;
	localparam logic [1:0] CFG_BUNDLE_KIND = 2'd3;

	// configuration reset values
	localparam logic [4:0] LINK_USED_RST   = 5'd0;
	localparam logic [4:0] MERGE_USED_RST  = 5'd0;
	localparam logic [3:0] RELOC_KIND_RST  = 4'd1;
	localparam logic [3:0] BUNDLE_KIND_RST = 4'd5;

	// score bits
	localparam int LINK_BIT_OWN    = 5;
	localparam int LINK_BIT_TARGET = 4;
	localparam int LINK_BIT_INFMT  = 3;
	localparam int LINK_BIT_OUTFMT = 2;
	localparam int LINK_BIT_KIND   = 1;
	localparam int LINK_BIT_KEY    = 0;
	localparam int MERGE_BIT_OWN    = 3;
	localparam int MERGE_BIT_TARGET = 2;
	localparam int MERGE_BIT_FMT    = 1;
	localparam int MERGE_BIT_KEY    = 0;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic        builtin;
		logic [31:0] provider_code;
		logic [63:0] target_id;
		logic [63:0] input_format;
		logic [63:0] output_format;
		logic [3:0]  output_kind;
		logic [31:0] compat_key;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic       route;
		logic [3:0] entry;
		logic [5:0] score;
	} out_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CHECK,
		ST_SCAN,
		ST_RESULT
	} state_t;

endpackage

// File: rtl/msrs_ram.sv
module msrs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                         wdata,
	input  logic                                     re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// single write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: rtl/most_specific_route_select.sv
// channel  direction  handshake            payload
// in       input      in_valid / in_stall  in_data  (msrs_pkg::in_t)
// out      output     out_valid/out_stall  out_data (msrs_pkg::out_t)
// cfg      input      cfg_wr_en            cfg_index, cfg_data
//
// a load item or an ignored item is taken in the idle state; an invalid request goes
// through check and result, a valid request through check, a scan of the used entries
// of its table and result, scoring one entry a cycle off the table read port
// reset restores the configuration defaults; table contents stay undefined until loaded
// a finished result sits in the output register, and the next item is taken meanwhile
// while the output register is full and stalled, a new result waits in its last state
module most_specific_route_select #(
	parameter int TABLE_DEPTH = 16,
	parameter int ID_WIDTH    = 64,
	parameter int KEY_WIDTH   = 32
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  msrs_pkg::in_t  in_data,
	output logic           out_valid,
	input  logic           out_stall,
	output msrs_pkg::out_t out_data,
	input  logic           cfg_wr_en,
	input  logic [1:0]     cfg_index,
	input  logic [4:0]     cfg_data
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	// link entry layout
	localparam int L_TGT  = 0;
	localparam int L_IN   = ID_WIDTH;
	localparam int L_OUT  = 2 * ID_WIDTH;
	localparam int L_BI   = 3 * ID_WIDTH;
	localparam int L_KIND = 3 * ID_WIDTH + 1;
	localparam int L_KEY  = 3 * ID_WIDTH + 5;
	localparam int L_PROV = 3 * ID_WIDTH + 5 + KEY_WIDTH;
	localparam int LW     = 3 * ID_WIDTH + 5 + 2 * KEY_WIDTH;

	// merge entry layout
	localparam int M_TGT  = 0;
	localparam int M_FMT  = ID_WIDTH;
	localparam int M_BI   = 2 * ID_WIDTH;
	localparam int M_KEY  = 2 * ID_WIDTH + 1;
	localparam int M_PROV = 2 * ID_WIDTH + 1 + KEY_WIDTH;
	localparam int MW     = 2 * ID_WIDTH + 1 + 2 * KEY_WIDTH;

	msrs_pkg::state_t state_q, state_d;

	// configuration
	logic [4:0] link_used_q, merge_used_q;
	logic [3:0] reloc_kind_q, bundle_kind_q;

	// latched request
	logic [KEY_WIDTH-1:0] req_prov_q, req_key_q;
	logic [ID_WIDTH-1:0]  req_tgt_q, req_in_q, req_out_q;
	logic [3:0]           req_kind_q;

	// scan control
	logic          merge_q, invalid_q;
	logic [CW-1:0] n_q, cnt_q;
	logic          rd_pend_s1;
	logic [AW-1:0] idx_s1;
	logic          best_valid_q, amb_q;
	logic [5:0]    best_score_q;
	logic [AW-1:0] best_idx_q;

	// output register
	logic           out_valid_q;
	msrs_pkg::out_t out_q;

	logic in_xfer, out_free, ram_re;
	logic req_bad, req_merge;
	logic [31:0] used_sel;
	logic [CW-1:0] n_clamp;
	logic link_we, merge_we;
	logic [AW-1:0] wr_addr, rd_addr;
	logic [31:0] slot_ext;
	logic [LW-1:0] link_wdata, link_rdata;
	logic [MW-1:0] merge_wdata, merge_rdata;
	logic       link_hit, merge_hit, hit;
	logic [5:0] link_score, merge_score, score;

	assign in_xfer   = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;
	assign in_stall  = (state_q != msrs_pkg::ST_IDLE);
	assign ram_re    = (state_q == msrs_pkg::ST_SCAN) && (cnt_q != n_q);
	assign rd_addr   = cnt_q[AW-1:0];

	// table writes from load items
	assign slot_ext = 32'(in_data.slot);
	assign wr_addr  = slot_ext[AW-1:0];
	assign link_we  = in_xfer && (in_data.kind == msrs_pkg::KIND_LOAD_LINK) &&
		(slot_ext < 32'(TABLE_DEPTH));
	assign merge_we = in_xfer && (in_data.kind == msrs_pkg::KIND_LOAD_MERGE) &&
		(slot_ext < 32'(TABLE_DEPTH));
	assign link_wdata = {in_data.provider_code[KEY_WIDTH-1:0],
		in_data.compat_key[KEY_WIDTH-1:0], in_data.output_kind, in_data.builtin,
		in_data.output_format[ID_WIDTH-1:0], in_data.input_format[ID_WIDTH-1:0],
		in_data.target_id[ID_WIDTH-1:0]};
	assign merge_wdata = {in_data.provider_code[KEY_WIDTH-1:0],
		in_data.compat_key[KEY_WIDTH-1:0], in_data.builtin,
		in_data.output_format[ID_WIDTH-1:0], in_data.target_id[ID_WIDTH-1:0]};

	msrs_ram #(.WIDTH(LW), .DEPTH(TABLE_DEPTH)) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (wr_addr),
		.wdata (link_wdata),
		.re    (ram_re && !merge_q),
		.raddr (rd_addr),
		.rdata (link_rdata)
	);

	msrs_ram #(.WIDTH(MW), .DEPTH(TABLE_DEPTH)) u_merge_ram (
		.clk   (clk),
		.we    (merge_we),
		.waddr (wr_addr),
		.wdata (merge_wdata),
		.re    (ram_re && merge_q),
		.raddr (rd_addr),
		.rdata (merge_rdata)
	);

	// request validation and table choice
	assign req_bad = (req_tgt_q == '0) || (req_out_q == '0) ||
		(req_kind_q < reloc_kind_q) || (req_kind_q > bundle_kind_q);
	assign req_merge = (req_kind_q == reloc_kind_q);
	assign used_sel  = req_merge ? 32'(merge_used_q) : 32'(link_used_q);
	assign n_clamp   = (used_sel > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : CW'(used_sel);

	// link entry score and match logic
	always_comb begin
		link_score = '0;
		link_score[msrs_pkg::LINK_BIT_OWN]    = !link_rdata[L_BI];
		link_score[msrs_pkg::LINK_BIT_TARGET] = (link_rdata[L_TGT +: ID_WIDTH] != '0);
		link_score[msrs_pkg::LINK_BIT_INFMT]  = (link_rdata[L_IN +: ID_WIDTH] != '0);
		link_score[msrs_pkg::LINK_BIT_OUTFMT] = (link_rdata[L_OUT +: ID_WIDTH] != '0);
		link_score[msrs_pkg::LINK_BIT_KIND]   = (link_rdata[L_KIND +: 4] != '0);
		link_score[msrs_pkg::LINK_BIT_KEY]    = (link_rdata[L_KEY +: KEY_WIDTH] != '0);
		link_hit = !((req_prov_q != '0) && (link_rdata[L_PROV +: KEY_WIDTH] != req_prov_q)) &&
			!(link_score[msrs_pkg::LINK_BIT_TARGET] &&
				(link_rdata[L_TGT +: ID_WIDTH] != req_tgt_q)) &&
			!(link_score[msrs_pkg::LINK_BIT_INFMT] &&
				(link_rdata[L_IN +: ID_WIDTH] != req_in_q)) &&
			!(link_score[msrs_pkg::LINK_BIT_OUTFMT] &&
				(link_rdata[L_OUT +: ID_WIDTH] != req_out_q)) &&
			!(link_score[msrs_pkg::LINK_BIT_KIND] &&
				(link_rdata[L_KIND +: 4] != req_kind_q)) &&
			!(link_score[msrs_pkg::LINK_BIT_KEY] &&
				(link_rdata[L_KEY +: KEY_WIDTH] != req_key_q));
	end

	// merge entry score and match logic
	always_comb begin
		merge_score = '0;
		merge_score[msrs_pkg::MERGE_BIT_OWN]    = !merge_rdata[M_BI];
		merge_score[msrs_pkg::MERGE_BIT_TARGET] = (merge_rdata[M_TGT +: ID_WIDTH] != '0);
		merge_score[msrs_pkg::MERGE_BIT_FMT]    = (merge_rdata[M_FMT +: ID_WIDTH] != '0);
		merge_score[msrs_pkg::MERGE_BIT_KEY]    = (merge_rdata[M_KEY +: KEY_WIDTH] != '0);
		merge_hit = !((req_prov_q != '0) &&
				(merge_rdata[M_PROV +: KEY_WIDTH] != req_prov_q)) &&
			!(merge_score[msrs_pkg::MERGE_BIT_TARGET] &&
				(merge_rdata[M_TGT +: ID_WIDTH] != req_tgt_q)) &&
			!(merge_score[msrs_pkg::MERGE_BIT_FMT] &&
				(merge_rdata[M_FMT +: ID_WIDTH] != req_out_q)) &&
			!(merge_score[msrs_pkg::MERGE_BIT_KEY] &&
				(merge_rdata[M_KEY +: KEY_WIDTH] != req_key_q));
	end

	assign hit   = merge_q ? merge_hit : link_hit;
	assign score = merge_q ? merge_score : link_score;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msrs_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			msrs_pkg::ST_IDLE: begin
				if (in_xfer && (in_data.kind == msrs_pkg::KIND_REQUEST)) begin
					state_d = msrs_pkg::ST_CHECK;
				end
			end
			msrs_pkg::ST_CHECK: begin
				state_d = req_bad ? msrs_pkg::ST_RESULT : msrs_pkg::ST_SCAN;
			end
			msrs_pkg::ST_SCAN: begin
				// the last read is rated at the edge that leaves the scan
				if (cnt_q == n_q) begin
					state_d = msrs_pkg::ST_RESULT;
				end
			end
			msrs_pkg::ST_RESULT: begin
				if (out_free) begin
					state_d = msrs_pkg::ST_IDLE;
				end
			end
			default: state_d = msrs_pkg::ST_IDLE;
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_used_q   <= msrs_pkg::LINK_USED_RST;
			merge_used_q  <= msrs_pkg::MERGE_USED_RST;
			reloc_kind_q  <= msrs_pkg::RELOC_KIND_RST;
			bundle_kind_q <= msrs_pkg::BUNDLE_KIND_RST;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				msrs_pkg::CFG_LINK_USED:   link_used_q   <= cfg_data;
				msrs_pkg::CFG_MERGE_USED:  merge_used_q  <= cfg_data;
				msrs_pkg::CFG_RELOC_KIND:  reloc_kind_q  <= cfg_data[3:0];
				msrs_pkg::CFG_BUNDLE_KIND: bundle_kind_q <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	// request capture, tags cut to the configured widths
	always_ff @(posedge clk) begin
		if (in_xfer && (in_data.kind == msrs_pkg::KIND_REQUEST)) begin
			req_prov_q <= in_data.provider_code[KEY_WIDTH-1:0];
			req_key_q  <= in_data.compat_key[KEY_WIDTH-1:0];
			req_tgt_q  <= in_data.target_id[ID_WIDTH-1:0];
			req_in_q   <= in_data.input_format[ID_WIDTH-1:0];
			req_out_q  <= in_data.output_format[ID_WIDTH-1:0];
			req_kind_q <= in_data.output_kind;
		end
	end

	// scan sequencer and best-entry tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_q      <= 1'b0;
			invalid_q    <= 1'b0;
			n_q          <= '0;
			cnt_q        <= '0;
			rd_pend_s1   <= 1'b0;
			best_valid_q <= 1'b0;
			amb_q        <= 1'b0;
		end else begin
			unique case (state_q)
				msrs_pkg::ST_CHECK: begin
					invalid_q    <= req_bad;
					merge_q      <= req_merge;
					n_q          <= n_clamp;
					cnt_q        <= '0;
					rd_pend_s1   <= 1'b0;
					best_valid_q <= 1'b0;
					amb_q        <= 1'b0;
				end
				msrs_pkg::ST_SCAN: begin
					rd_pend_s1 <= ram_re;
					if (ram_re) begin
						cnt_q <= cnt_q + CW'(1);
					end
					if (rd_pend_s1 && hit) begin
						if (!best_valid_q || (score > best_score_q)) begin
							best_valid_q <= 1'b1;
							amb_q        <= 1'b0;
						end else if (score == best_score_q) begin
							amb_q <= 1'b1;
						end
					end
				end
				default: ;
			endcase
		end
	end

	// best entry payload
	always_ff @(posedge clk) begin
		if (ram_re) begin
			idx_s1 <= rd_addr;
		end
		if ((state_q == msrs_pkg::ST_SCAN) && rd_pend_s1 && hit &&
			(!best_valid_q || (score > best_score_q))) begin
			best_score_q <= score;
			best_idx_q   <= idx_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if ((state_q == msrs_pkg::ST_RESULT) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == msrs_pkg::ST_RESULT) && out_free) begin
			priority if (invalid_q) begin
				out_q.status <= msrs_pkg::STATUS_INVALID;
				out_q.route  <= 1'b0;
				out_q.entry  <= '0;
				out_q.score  <= '0;
			end else if (!best_valid_q) begin
				out_q.status <= msrs_pkg::STATUS_NO_ROUTE;
				out_q.route  <= !merge_q;
				out_q.entry  <= '0;
				out_q.score  <= '0;
			end else begin
				out_q.status <= amb_q ? msrs_pkg::STATUS_AMBIGUOUS : msrs_pkg::STATUS_OK;
				out_q.route  <= !merge_q;
				out_q.entry  <= 4'(best_idx_q);
				out_q.score  <= best_score_q;
			end
		end
	end

	// a new result only comes out of the result state
	a_result_from_fsm: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q == msrs_pkg::ST_RESULT))
		else $error("result issued outside the result state");

	// an invalid request reports nothing else
	a_invalid_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (out_data.status == msrs_pkg::STATUS_INVALID)) |->
		(!out_data.route && (out_data.entry == '0) && (out_data.score == '0)))
		else $error("invalid request carries route data");

	// table reads are only outstanding during a scan
	a_read_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_pend_s1 |-> (state_q == msrs_pkg::ST_SCAN) && $past(state_q == msrs_pkg::ST_SCAN))
		else $error("table read outstanding outside a scan");

endmodule
